// File: rtl/core/ribp_pkg.sv
// ----------------------------------------------------------------------------
// ribp_pkg
// Shared types and constants for the ranged integer bit packer.
// ----------------------------------------------------------------------------
package ribp_pkg;

  localparam int VAL_W   = 64;
  localparam int BYTE_W  = 8;
  localparam int IDATA_W = 3 * VAL_W;
  localparam int IUSER_W = 2;
  localparam int OUSER_W = 1;

  localparam int UFUNC_BIT = 0;
  localparam int USIGN_BIT = 1;

  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_FLUSH = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FLUSH,
    ST_CALC,
    ST_EVAL,
    ST_PACK,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic load;
    logic calc;
    logic step;
    logic push_err;
    logic fin;
    logic flush;
  } cmd_t;

  typedef struct packed {
    logic err;
    logic range_zero;
    logic step_emit;
    logic pend_v;
    logic out_free;
    logic used_nz;
  } sts_t;

endpackage

// File: rtl/core/ribp_ctrl.sv
// ----------------------------------------------------------------------------
// ribp_ctrl
// Sequencer for one request: bound check, byte-wise pack loop, flush.
// ----------------------------------------------------------------------------
module ribp_ctrl import ribp_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_fire,
  input  logic in_func,
  input  sts_t sts,
  output logic in_ready,
  output cmd_t cmd
);

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_fire) begin
          cmd.load  = 1'b1;
          state_nxt = (in_func == FUNC_FLUSH) ? ST_FLUSH : ST_CALC;
        end
      end
      ST_FLUSH: begin
        if (!sts.used_nz || sts.out_free) begin
          cmd.flush = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      ST_CALC: begin
        cmd.calc  = 1'b1;
        state_nxt = ST_EVAL;
      end
      ST_EVAL: begin
        if (sts.err) begin
          if (sts.out_free) begin
            cmd.push_err = 1'b1;
            state_nxt    = ST_IDLE;
          end
        end else begin
          state_nxt = ST_PACK;
        end
      end
      ST_PACK: begin
        if (sts.range_zero) begin
          state_nxt = ST_FIN;
        end else if (!(sts.step_emit && sts.pend_v && !sts.out_free)) begin
          cmd.step = 1'b1;
        end
      end
      ST_FIN: begin
        if (!sts.pend_v) begin
          state_nxt = ST_IDLE;
        end else if (sts.out_free) begin
          cmd.fin   = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

// File: rtl/core/ribp_datapath.sv
// ----------------------------------------------------------------------------
// ribp_datapath
// Operand registers, bound compare, offset shifter, bit packer, output stage.
// ----------------------------------------------------------------------------
module ribp_datapath import ribp_pkg::*; #(
  parameter int MAX_WIDTH = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  cmd_t               cmd,
  input  logic [IDATA_W-1:0] in_data,
  input  logic               in_signed,
  input  logic               out_ready,
  output sts_t               sts,
  output logic               out_valid,
  output logic [BYTE_W-1:0]  out_byte,
  output logic               out_err,
  output logic               out_last
);

  function automatic logic [3:0] bits8(input logic [7:0] x);
    logic [3:0] n;
    n = 4'd0;
    for (int i = 0; i < 8; i++) begin
      if (x[i]) n = 4'(i + 1);
    end
    return n;
  endfunction

  function automatic logic [7:0] mask8(input logic [3:0] n);
    return 8'hFF >> (4'd8 - n);
  endfunction

  logic [VAL_W-1:0]     val_r;
  logic [VAL_W-1:0]     lo_r;
  logic [VAL_W-1:0]     hi_r;
  logic                 sgn_r;
  logic                 bad_r;
  logic [VAL_W-1:0]     range_r;
  logic [MAX_WIDTH-1:0] offset_r;
  logic [7:0]           partial_r;
  logic [2:0]           used_r;
  logic [7:0]           pend_r;
  logic                 pend_v_r;
  logic                 out_valid_r;
  logic [7:0]           out_byte_r;
  logic                 out_err_r;
  logic                 out_last_r;

  logic [VAL_W-1:0] flip;
  logic [VAL_W-1:0] cv;
  logic [VAL_W-1:0] cl;
  logic [VAL_W-1:0] ch;
  logic             bad_calc;
  logic [VAL_W-1:0] offset_full;

  assign flip        = {sgn_r, {(VAL_W-1){1'b0}}};
  assign cv          = val_r ^ flip;
  assign cl          = lo_r ^ flip;
  assign ch          = hi_r ^ flip;
  assign bad_calc    = !(cl < ch) || (cv < cl) || (cv > ch);
  assign offset_full = val_r - lo_r;

  logic [7:0] part_nxt;
  logic [2:0] used_nxt;
  logic       emit_v;
  logic [7:0] emit_byte;

  always_comb begin
    logic [7:0] src;
    logic [3:0] b;
    logic [3:0] r;
    logic [3:0] n;
    logic [3:0] rem;
    logic [7:0] fill;
    src       = offset_r[7:0];
    b         = (|(range_r >> 8)) ? 4'd8 : bits8(range_r[7:0]);
    n         = 4'd0;
    r         = 4'd0;
    fill      = 8'd0;
    part_nxt  = partial_r;
    used_nxt  = used_r;
    emit_v    = 1'b0;
    emit_byte = 8'd0;
    if (used_r != 3'd0) begin
      r        = 4'd8 - {1'b0, used_r};
      n        = (b < r) ? b : r;
      fill     = (src & mask8(n)) << (r - n);
      part_nxt = partial_r | fill;
      if (n == r) begin
        emit_v    = 1'b1;
        emit_byte = part_nxt;
        part_nxt  = 8'd0;
        used_nxt  = 3'd0;
      end else begin
        used_nxt = used_r + n[2:0];
      end
    end
    rem = b - n;
    if (rem != 4'd0) begin
      fill = ((src >> n) & mask8(rem)) << (4'd8 - rem);
      if (rem == 4'd8) begin
        emit_v    = 1'b1;
        emit_byte = fill;
        part_nxt  = 8'd0;
        used_nxt  = 3'd0;
      end else begin
        part_nxt = fill;
        used_nxt = rem[2:0];
      end
    end
  end

  logic out_free;
  assign out_free = !out_valid_r || out_ready;

  logic       ld_v;
  logic [7:0] ld_byte;
  logic       ld_err;
  logic       ld_last;

  always_comb begin
    ld_v    = 1'b0;
    ld_byte = pend_r;
    ld_err  = 1'b0;
    ld_last = 1'b0;
    if (cmd.flush && (used_r != 3'd0)) begin
      ld_v    = 1'b1;
      ld_byte = partial_r;
      ld_last = 1'b1;
    end
    if (cmd.push_err) begin
      ld_v    = 1'b1;
      ld_byte = 8'd0;
      ld_err  = 1'b1;
      ld_last = 1'b1;
    end
    if (cmd.step && emit_v && pend_v_r) begin
      ld_v    = 1'b1;
      ld_byte = pend_r;
    end
    if (cmd.fin) begin
      ld_v    = 1'b1;
      ld_byte = pend_r;
      ld_last = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      val_r <= in_data[VAL_W-1:0];
      lo_r  <= in_data[2*VAL_W-1:VAL_W];
      hi_r  <= in_data[3*VAL_W-1:2*VAL_W];
      sgn_r <= in_signed;
    end
    if (cmd.calc) begin
      bad_r    <= bad_calc;
      range_r  <= hi_r - lo_r;
      offset_r <= offset_full[MAX_WIDTH-1:0];
    end else if (cmd.step) begin
      range_r  <= range_r >> 8;
      offset_r <= offset_r >> 8;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      partial_r   <= 8'd0;
      used_r      <= 3'd0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (ld_v) begin
        out_valid_r <= 1'b1;
        out_byte_r  <= ld_byte;
        out_err_r   <= ld_err;
        out_last_r  <= ld_last;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (cmd.flush) begin
        partial_r <= 8'd0;
        used_r    <= 3'd0;
      end
      if (cmd.step) begin
        partial_r <= part_nxt;
        used_r    <= used_nxt;
        if (emit_v) begin
          pend_r   <= emit_byte;
          pend_v_r <= 1'b1;
        end
      end
      if (cmd.fin) begin
        pend_v_r <= 1'b0;
      end
    end
  end

  assign sts.err        = bad_r || ((range_r >> MAX_WIDTH) != '0);
  assign sts.range_zero = (range_r == '0);
  assign sts.step_emit  = emit_v;
  assign sts.pend_v     = pend_v_r;
  assign sts.out_free   = out_free;
  assign sts.used_nz    = (used_r != 3'd0);

  assign out_valid = out_valid_r;
  assign out_byte  = out_byte_r;
  assign out_err   = out_err_r;
  assign out_last  = out_last_r;

endmodule

// File: rtl/core/ranged_integer_bit_packer_top.sv
// ----------------------------------------------------------------------------
// ranged_integer_bit_packer_top
// Packs bounded integers into a byte stream using only the bits of the range.
// ----------------------------------------------------------------------------
// One request at a time. A write steps through capture, compare and
// subtract, check, then one pack step per offset byte (1 to 8, set by the
// range width, one byte through the packer per cycle unless a full output
// stalls it), then closes (end of range seen, last byte released); an
// error request finishes after its check, a flush after its flush step.
// A full output register stalls the request until the sink takes it.
module ranged_integer_bit_packer_top import ribp_pkg::*; #(
  parameter int MAX_WIDTH = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [IDATA_W-1:0] in_tdata,  // value, low_bound, high_bound
  input  logic [IUSER_W-1:0] in_tuser,  // func, is_signed
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [BYTE_W-1:0]  out_tdata, // out_byte
  output logic [OUSER_W-1:0] out_tuser, // error
  output logic               out_tlast
);

  cmd_t cmd;
  sts_t sts;
  logic in_fire;

  assign in_fire = in_tvalid && in_tready;

  ribp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_fire  (in_fire),
    .in_func  (in_tuser[UFUNC_BIT]),
    .sts      (sts),
    .in_ready (in_tready),
    .cmd      (cmd)
  );

  ribp_datapath #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_data   (in_tdata),
    .in_signed (in_tuser[USIGN_BIT]),
    .out_ready (out_tready),
    .sts       (sts),
    .out_valid (out_tvalid),
    .out_byte  (out_tdata),
    .out_err   (out_tuser[0]),
    .out_last  (out_tlast)
  );

endmodule

// File: tb/ranged_integer_bit_packer_top_tb.sv
// ----------------------------------------------------------------------------
// ranged_integer_bit_packer_top_tb
// Drives bounded-integer write and flush requests into the packer and checks
// every output byte and error result against a cycle-free packing predictor.
// A short table of directed requests comes first, then random request bursts
// with random sink stalls.
// ----------------------------------------------------------------------------
module ranged_integer_bit_packer_top_tb import ribp_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int PK_MAX_W = 64;
  localparam int N_RAND   = 330;
  localparam int N_DIR    = 23;

  typedef enum logic [1:0] {
    CHK_MODEL,
    CHK_NONE,
    CHK_ONE
  } row_chk_t;

  typedef struct packed {
    logic         func;
    logic         sgn;
    logic [63:0]  value;
    logic [63:0]  lo;
    logic [63:0]  hi;
    row_chk_t     chk;
    logic [7:0]   xbyte;
    logic         xerr;
  } dir_row_t;

  typedef struct packed {
    logic [7:0] data;
    logic       err;
    logic       last;
  } pk_res_t;

  localparam logic [63:0] ALL1 = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] SMIN = 64'h8000_0000_0000_0000;
  localparam logic [63:0] SMAX = 64'h7FFF_FFFF_FFFF_FFFF;

  localparam dir_row_t DIR_TAB [0:N_DIR-1] = '{
    '{FUNC_FLUSH, 1'b1, ALL1, ALL1, ALL1, CHK_NONE, 8'h00, 1'b0},
    '{FUNC_WRITE, 1'b0, 64'hAB, 64'd0, 64'hFF, CHK_ONE, 8'hAB, 1'b0},
    '{FUNC_WRITE, 1'b0, 64'd5, 64'd5, 64'd5, CHK_ONE, 8'h00, 1'b1},
    '{FUNC_WRITE, 1'b0, 64'd5, 64'd10, 64'd3, CHK_ONE, 8'h00, 1'b1},
    '{FUNC_WRITE, 1'b0, 64'd2, 64'd3, 64'd10, CHK_ONE, 8'h00, 1'b1},
    '{FUNC_WRITE, 1'b0, 64'd11, 64'd3, 64'd10, CHK_ONE, 8'h00, 1'b1},
    '{FUNC_WRITE, 1'b1, 64'd0, ALL1, 64'd1, CHK_MODEL, 8'h00, 1'b0},
    '{FUNC_WRITE, 1'b0, 64'd0, ALL1, 64'd1, CHK_ONE, 8'h00, 1'b1},
    '{FUNC_WRITE, 1'b1, SMIN, 64'hFFFF_FFFF_FFFF_FFFB, 64'd5, CHK_ONE, 8'h00, 1'b1},
    '{FUNC_WRITE, 1'b0, 64'h55, 64'd0, 64'h7F, CHK_MODEL, 8'h00, 1'b0},
    '{FUNC_FLUSH, 1'b0, 64'd0, 64'd0, 64'd0, CHK_MODEL, 8'h00, 1'b0},
    '{FUNC_FLUSH, 1'b0, 64'd0, 64'd0, 64'd0, CHK_NONE, 8'h00, 1'b0},
    '{FUNC_WRITE, 1'b0, ALL1, 64'd0, ALL1, CHK_MODEL, 8'h00, 1'b0},
    '{FUNC_WRITE, 1'b1, SMIN, SMIN, SMAX, CHK_MODEL, 8'h00, 1'b0},
    '{FUNC_WRITE, 1'b0, 64'h1234_5678, 64'd0, 64'hFFFF_FFFF, CHK_MODEL, 8'h00, 1'b0},
    '{FUNC_WRITE, 1'b0, 64'd1, 64'd0, 64'd1, CHK_MODEL, 8'h00, 1'b0},
    '{FUNC_WRITE, 1'b0, 64'h1ABC, 64'd0, 64'h1FFF, CHK_MODEL, 8'h00, 1'b0},
    '{FUNC_WRITE, 1'b1, 64'd100, 64'hFFFF_FFFF_FFFF_FF9C, 64'd100, CHK_MODEL, 8'h00, 1'b0},
    '{FUNC_WRITE, 1'b0, ALL1, 64'hFFFF_FFFF_FFFF_FFFE, ALL1, CHK_MODEL, 8'h00, 1'b0},
    '{FUNC_WRITE, 1'b1, 64'hFFFF_FFFF_FFFF_FFF8, 64'hFFFF_FFFF_FFFF_FFF8, 64'd7,
      CHK_MODEL, 8'h00, 1'b0},
    '{FUNC_WRITE, 1'b0, 64'hFFFF_FFFF_0000_0001, 64'd0, ALL1, CHK_MODEL, 8'h00, 1'b0},
    '{FUNC_FLUSH, 1'b1, 64'hDEAD_BEEF_0BAD_F00D, ALL1, 64'd0, CHK_MODEL, 8'h00, 1'b0},
    '{FUNC_WRITE, 1'b1, 64'd0, 64'd0, 64'd0, CHK_ONE, 8'h00, 1'b1}
  };

  logic               clk;
  logic               rst_n;
  logic               in_tvalid;
  logic               in_tready;
  logic [IDATA_W-1:0] in_tdata;
  logic [IUSER_W-1:0] in_tuser;
  logic               out_tvalid;
  logic               out_tready = 1'b0;
  logic [BYTE_W-1:0]  out_tdata;
  logic [OUSER_W-1:0] out_tuser;
  logic               out_tlast;

  pk_res_t     bytes_q [$];
  logic [7:0]  pk_partial;
  logic [2:0]  pk_used;
  int          fail_cnt;
  int          n_req;
  int          n_flush;
  int          n_bytes;
  int          n_err_res;
  int unsigned sink_cyc;

  ranged_integer_bit_packer_top #(
    .MAX_WIDTH (PK_MAX_W)
  ) i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("timeout: %0d results still pending", bytes_q.size());
    $display("ranged_integer_bit_packer_top verification failed");
    $finish;
  end

  function automatic logic [63:0] rnd64();
    return {$urandom, $urandom};
  endfunction

  task automatic note_mismatch(input string what);
    fail_cnt++;
    $display("MISMATCH @%0t: %s", $realtime, what);
  endtask

  // Bit packing predictor: updates the partial byte and queues emitted bytes, flush bytes and error results.
  function automatic void predict_packing(input logic f, input logic sgn,
                                          input logic [63:0] v, lo, hi);
    logic [63:0] flip, cv, cl, ch, span, off;
    int unsigned nb, done, idx, src, b, n, r, rem, k;
    logic [7:0]  nbyte;
    pk_res_t     res [8];
    pk_res_t     one;
    nb = 0;
    done = 0;
    k = 0;
    if (f == FUNC_FLUSH) begin
      if (pk_used != 0) begin
        one = '{data: pk_partial, err: 1'b0, last: 1'b1};
        bytes_q = {bytes_q, one};
      end
      pk_partial = '0;
      pk_used = '0;
      return;
    end
    flip = sgn ? SMIN : 64'd0;
    cv = v ^ flip;
    cl = lo ^ flip;
    ch = hi ^ flip;
    span = hi - lo;
    for (int i = 0; i < 64; i++) if (span[i]) nb = i + 1;
    if (!(cl < ch) || cv < cl || cv > ch || nb > PK_MAX_W) begin
      one = '{data: 8'h00, err: 1'b1, last: 1'b1};
      bytes_q = {bytes_q, one};
      return;
    end
    off = v - lo;
    for (idx = 0; idx < 8 && done < nb; idx++) begin
      src = 32'((off >> (8 * idx)) & 64'hFF);
      b = nb - done;
      if (b > 8) b = 8;
      n = 0;
      if (pk_used != 0) begin
        r = 8 - pk_used;
        n = (b < r) ? b : r;
        pk_partial = pk_partial | 8'((src & ((1 << n) - 1)) << (r - n));
        if (n == r) begin
          if (k < 8) begin
            res[k] = '{data: pk_partial, err: 1'b0, last: 1'b0};
            k++;
          end
          pk_partial = '0;
          pk_used = '0;
        end else begin
          pk_used = 3'(pk_used + n);
        end
      end
      rem = b - n;
      if (rem != 0) begin
        nbyte = 8'(((src >> n) & ((1 << rem) - 1)) << (8 - rem));
        if (rem == 8) begin
          if (k < 8) begin
            res[k] = '{data: nbyte, err: 1'b0, last: 1'b0};
            k++;
          end
          pk_partial = '0;
          pk_used = '0;
        end else begin
          pk_partial = nbyte;
          pk_used = 3'(rem);
        end
      end
      done += b;
    end
    for (int j = 0; j < k; j++) begin
      res[j].last = (j == k - 1);
      bytes_q = {bytes_q, res[j]};
    end
  endfunction

  task automatic send_req(input logic f, input logic sgn, input logic [63:0] v, lo, hi,
                          output int first, output int added);
    in_tvalid <= 1'b1;
    in_tdata  <= {hi, lo, v};
    in_tuser  <= {sgn, f};
    do @(posedge clk); while (!in_tready);
    first = bytes_q.size();
    predict_packing(f, sgn, v, lo, hi);
    added = bytes_q.size() - first;
    n_req++;
    if (f == FUNC_FLUSH) n_flush++;
  endtask

  task automatic hold_off(input int cycles);
    if (cycles > 0) begin
      in_tvalid <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  // result checker and sink stall pattern
  always @(posedge clk) begin
    pk_res_t exp_r;
    int      mode;
    if (rst_n && out_tvalid && out_tready) begin
      if (bytes_q.size() == 0) begin
        note_mismatch($sformatf("unexpected result byte=%02h err=%0b last=%0b",
                                out_tdata, out_tuser[0], out_tlast));
      end else begin
        exp_r = bytes_q.pop_front();
        if (out_tdata !== exp_r.data)
          note_mismatch($sformatf("out_byte %02h, want %02h", out_tdata, exp_r.data));
        if (out_tuser[0] !== exp_r.err)
          note_mismatch($sformatf("error %0b, want %0b", out_tuser[0], exp_r.err));
        if (out_tlast !== exp_r.last)
          note_mismatch($sformatf("last %0b, want %0b", out_tlast, exp_r.last));
        if (exp_r.err) n_err_res++;
        else n_bytes++;
      end
    end
    sink_cyc++;
    mode = (sink_cyc / 97) % 4;
    case (mode)
      0:       out_tready <= 1'b1;
      1:       out_tready <= $urandom_range(0, 1);
      2:       out_tready <= (sink_cyc % 4 == 0);
      default: out_tready <= ($urandom_range(0, 4) != 0);
    endcase
  end

  initial begin
    logic [63:0] span, c_lo, ch, cv, off, flip, v, lo, hi;
    logic        f, sgn;
    int          kind, w, burst_left, n0, added;
    fail_cnt = 0;
    n_req = 0;
    n_flush = 0;
    n_bytes = 0;
    n_err_res = 0;
    sink_cyc = 0;
    pk_partial = '0;
    pk_used = '0;
    burst_left = 0;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table
    for (int i = 0; i < N_DIR; i++) begin
      send_req(DIR_TAB[i].func, DIR_TAB[i].sgn, DIR_TAB[i].value, DIR_TAB[i].lo,
               DIR_TAB[i].hi, n0, added);
      if (DIR_TAB[i].chk == CHK_NONE && added != 0)
        note_mismatch($sformatf("row %0d: predictor gave %0d results, want none", i, added));
      if (DIR_TAB[i].chk == CHK_ONE && (added != 1 || bytes_q[n0].data != DIR_TAB[i].xbyte ||
          bytes_q[n0].err != DIR_TAB[i].xerr || !bytes_q[n0].last))
        note_mismatch($sformatf("row %0d: predictor disagrees with table", i));
      hold_off($urandom_range(0, 2));
    end

    // random bursts
    for (int i = 0; i < N_RAND; i++) begin
      if (i == N_RAND / 2) begin
        in_tvalid <= 1'b0;
        @(posedge clk);
        while (bytes_q.size() != 0) @(posedge clk);
      end else if (burst_left <= 0) begin
        burst_left = $urandom_range(1, 16);
        hold_off(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8));
      end
      burst_left--;

      f = FUNC_WRITE;
      sgn = $urandom_range(0, 1);
      flip = sgn ? SMIN : 64'd0;
      kind = $urandom_range(0, 99);
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5, 6: w = $urandom_range(1, 16);
        7, 8:                w = $urandom_range(17, 40);
        default:             w = $urandom_range(41, 64);
      endcase
      span = rnd64();
      if (w < 64) span = span & ((64'd1 << w) - 64'd1);
      span[w-1] = 1'b1;
      c_lo = (&span) ? 64'd0 : rnd64() % (~span + 64'd1);
      case ($urandom_range(0, 7))
        0:       off = 64'd0;
        1:       off = span;
        default: off = (&span) ? rnd64() : rnd64() % (span + 64'd1);
      endcase
      ch = c_lo + span;
      cv = c_lo + off;
      if (kind >= 70 && kind < 85) begin
        case ($urandom_range(0, 2))
          0: if (!(&ch)) cv = ch + 64'd1; else ch = c_lo;
          1: if (c_lo != 0) cv = c_lo - 64'd1; else ch = c_lo;
          default: {c_lo, ch} = {ch, c_lo};
        endcase
      end
      v = cv ^ flip;
      lo = c_lo ^ flip;
      hi = ch ^ flip;
      if (kind >= 60 && kind < 70) f = FUNC_FLUSH;
      if ((kind >= 60 && kind < 70) || kind >= 85) begin
        v = rnd64();
        lo = rnd64();
        hi = rnd64();
      end
      send_req(f, sgn, v, lo, hi, n0, added);
    end

    in_tvalid <= 1'b0;
    @(posedge clk);
    while (bytes_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    $display("covered %0d requests (%0d directed, %0d flushes)", n_req, N_DIR, n_flush);
    $display("checked %0d stream bytes and %0d error results", n_bytes, n_err_res);
    if (fail_cnt == 0) begin
      $display("ranged_integer_bit_packer_top verification clean");
    end else begin
      $display("%0d mismatches", fail_cnt);
      $display("ranged_integer_bit_packer_top verification failed");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/core/ribp_pkg.sv
rtl/core/ribp_ctrl.sv
rtl/core/ribp_datapath.sv
rtl/core/ranged_integer_bit_packer_top.sv
tb/ranged_integer_bit_packer_top_tb.sv
